// ===== hw/rtl/tlvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types and codes of the TLV record parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int SLOT_MAX  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED = 3'd0,
    CFG_EXTRA    = 3'd1,
    CFG_IDS_LOW  = 3'd2,
    CFG_IDS_HIGH = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_REC,
    PH_SUB,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_ID,
    OP_DATA
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_BAD_REC  = 3'd2,
    ST_BAD_SUB  = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  // one queue entry: what the front saw on one byte
  typedef struct packed {
    op_t         op;
    logic        fin;
    logic        chk;    // status comes from the match count check
    status_t     st;
    logic [7:0]  data;
    logic [15:0] id;
    logic [15:0] off;
    logic [15:0] len;
  } entry_t;

  typedef struct packed {
    logic [3:0]  expected_count;
    logic [3:0]  extra_count;
    logic [63:0] ids_low;
    logic [63:0] ids_high;
  } cfg_t;

endpackage

// ===== hw/rtl/tlvp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_front
// Byte parser: tracks record and sub-item framing, emits queue entries.
// ----------------------------------------------------------------------------
module tlvp_front #(
  parameter int MAX_RECORD = 131072
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             stream_end,
  input  logic             full,
  output logic             push,
  output tlvp_pkg::entry_t ent
);

  localparam int RLW = $clog2(MAX_RECORD);

  tlvp_pkg::phase_t phase, phase_next;
  logic [31:0]      header_shift, header_shift_next;
  logic [1:0]       header_count, header_count_next;
  logic [RLW-1:0]   record_left, record_left_next;
  logic [15:0]      sub_left, sub_left_next;
  logic [15:0]      sub_len, sub_len_next;
  logic             halted, halted_next;

  logic [31:0]      shift_in;
  logic [15:0]      len;
  logic [RLW-1:0]   rl_dec;
  logic [15:0]      data_len;
  logic             bad;
  logic             accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign shift_in = {header_shift[23:0], data_byte};
  assign len      = shift_in[15:0];
  assign rl_dec   = record_left - RLW'(1);
  assign data_len = sub_len - 16'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tlvp_pkg::PH_REC;
      header_shift <= '0;
      header_count <= '0;
      record_left  <= '0;
      sub_left     <= '0;
      sub_len      <= '0;
      halted       <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      header_shift <= header_shift_next;
      header_count <= header_count_next;
      record_left  <= record_left_next;
      sub_left     <= sub_left_next;
      sub_len      <= sub_len_next;
      halted       <= halted_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    header_shift_next = header_shift;
    header_count_next = header_count;
    record_left_next  = record_left;
    sub_left_next     = sub_left;
    sub_len_next      = sub_len;
    halted_next       = halted;
    bad               = 1'b0;
    ent               = '0;
    ent.data          = data_byte;

    if (halted) begin
      if (stream_end) begin
        halted_next       = 1'b0;
        phase_next        = tlvp_pkg::PH_REC;
        header_count_next = '0;
      end
    end else begin
      case (phase)
        tlvp_pkg::PH_REC: begin
          header_shift_next = shift_in;
          if (header_count != 2'd3) begin
            header_count_next = header_count + 2'd1;
          end else begin
            header_count_next = '0;
            if (shift_in < 32'd4 || shift_in > 32'(MAX_RECORD)) begin
              ent.fin = 1'b1;
              ent.st  = tlvp_pkg::ST_BAD_REC;
              bad     = 1'b1;
            end else begin
              record_left_next = RLW'(shift_in - 32'd4);
              ent.op           = tlvp_pkg::OP_START;
              if (shift_in == 32'd4) begin
                ent.fin = 1'b1;
                ent.chk = 1'b1;
              end else begin
                phase_next = tlvp_pkg::PH_SUB;
              end
            end
          end
        end
        tlvp_pkg::PH_SUB: begin
          header_shift_next = shift_in;
          if (header_count == 2'd1) begin
            if (len < 16'd4 || 32'(len) > 32'(record_left) + 32'd1) begin
              ent.fin = 1'b1;
              ent.st  = tlvp_pkg::ST_BAD_SUB;
              bad     = 1'b1;
            end else begin
              sub_len_next = len;
            end
          end
          if (!bad) begin
            record_left_next = rl_dec;
            if (header_count != 2'd3) begin
              header_count_next = header_count + 2'd1;
            end else begin
              header_count_next = '0;
              ent.op            = tlvp_pkg::OP_ID;
              ent.id            = len;
              sub_left_next     = data_len;
              if (data_len != 16'd0) begin
                phase_next = tlvp_pkg::PH_DATA;
              end else if (rl_dec == '0) begin
                ent.fin = 1'b1;
                ent.chk = 1'b1;
              end
            end
          end
        end
        tlvp_pkg::PH_DATA: begin
          record_left_next = rl_dec;
          ent.op           = tlvp_pkg::OP_DATA;
          ent.off          = data_len - sub_left;
          ent.len          = data_len;
          sub_left_next    = sub_left - 16'd1;
          if (sub_left == 16'd1) begin
            if (rl_dec == '0) begin
              ent.fin = 1'b1;
              ent.chk = 1'b1;
            end else begin
              phase_next = tlvp_pkg::PH_SUB;
            end
          end
        end
        default: begin
          phase_next = tlvp_pkg::PH_REC;
        end
      endcase

      if (!ent.fin && stream_end) begin
        ent.fin = 1'b1;
        ent.chk = 1'b0;
        ent.st  = tlvp_pkg::ST_TRUNC;
      end
      if (ent.fin) begin
        phase_next        = tlvp_pkg::PH_REC;
        header_count_next = '0;
        halted_next       = bad && !stream_end;
      end
    end
  end

  assign push = accept && !halted && (ent.op != tlvp_pkg::OP_NONE || ent.fin);

endmodule

// ===== hw/rtl/tlvp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_fifo
// Short entry queue between the byte parser and the match stage.
// ----------------------------------------------------------------------------
module tlvp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tlvp_pkg::entry_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output tlvp_pkg::entry_t rdata
);

  localparam int PW = $clog2(DEPTH);

  tlvp_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW:0]      count;
  logic             do_push, do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tlvp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_back
// Identifier matching, record status and the registered result stage.
// ----------------------------------------------------------------------------
module tlvp_back #(
  parameter int SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  tlvp_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  tlvp_pkg::entry_t ent,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             has_data,
  output logic [7:0]       out_byte,
  output logic [7:0]       slot_mask,
  output logic [15:0]      data_offset,
  output logic [15:0]      item_length,
  output logic             record_end,
  output logic [2:0]       status
);

  localparam int SM = tlvp_pkg::SLOT_MAX;

  logic [7:0]  cur_mask, cur_mask_next;
  logic [3:0]  match_count, match_count_next;

  logic [15:0] ids [SM];
  logic [3:0]  eff;
  logic [4:0]  tot_sum;
  logic [3:0]  tot;
  logic [SM-1:0] hits;
  logic [3:0]  hit_cnt;
  logic [4:0]  mc_sum;
  logic [3:0]  mc_base;
  logic        in_order;
  logic        hd, produce;
  tlvp_pkg::status_t st;

  always_comb begin
    for (int i = 0; i < SM; i++) begin
      if (i < 4) begin
        ids[i] = cfg.ids_low[16*i +: 16];
      end else begin
        ids[i] = cfg.ids_high[16*(i-4) +: 16];
      end
    end
  end

  assign eff     = (cfg.expected_count > 4'(SLOTS)) ? 4'(SLOTS) : cfg.expected_count;
  assign tot_sum = {1'b0, cfg.expected_count} + {1'b0, cfg.extra_count};
  assign tot     = (tot_sum > 5'(SLOTS)) ? 4'(SLOTS) : tot_sum[3:0];
  assign mc_base = (ent.op == tlvp_pkg::OP_START) ? 4'd0 : match_count;

  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < SM; i++) begin
      hits[i] = (i < SLOTS) && (4'(i) < tot) && (ids[i] == ent.id);
      hit_cnt = hit_cnt + {3'd0, hits[i]};
    end
  end

  assign in_order = (mc_base < eff) && (ids[mc_base[2:0]] == ent.id);
  assign mc_sum   = {1'b0, mc_base} + {1'b0, hit_cnt};

  always_comb begin
    cur_mask_next    = cur_mask;
    match_count_next = mc_base;
    case (ent.op)
      tlvp_pkg::OP_START: begin
        cur_mask_next = '0;
      end
      tlvp_pkg::OP_ID: begin
        if (in_order) begin
          cur_mask_next    = 8'(1) << mc_base[2:0];
          match_count_next = mc_base + 4'd1;
        end else begin
          cur_mask_next    = hits;
          match_count_next = (mc_sum > 5'd15) ? 4'd15 : mc_sum[3:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign hd      = (ent.op == tlvp_pkg::OP_DATA) && (cur_mask != '0);
  assign produce = hd || ent.fin;
  assign pop     = q_valid && (!out_valid || out_ready);

  always_comb begin
    if (!ent.chk) begin
      st = ent.st;
    end else if (match_count_next == eff) begin
      st = tlvp_pkg::ST_OK;
    end else begin
      st = tlvp_pkg::ST_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask    <= '0;
      match_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        cur_mask    <= cur_mask_next;
        match_count <= match_count_next;
        out_valid   <= produce;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      has_data    <= hd;
      out_byte    <= hd ? ent.data : 8'd0;
      slot_mask   <= hd ? cur_mask : 8'd0;
      data_offset <= hd ? ent.off : 16'd0;
      item_length <= hd ? ent.len : 16'd0;
      record_end  <= ent.fin;
      status      <= ent.fin ? st : tlvp_pkg::ST_OK;
    end
  end

endmodule

// ===== hw/rtl/tlv_record_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_record_parser_top
// Byte-serial TLV record parser with identifier slot matching.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while in_ready is high. The parser front
// updates framing state in the cycle a byte is accepted and writes an entry,
// if the byte yields one, into a QUEUE_DEPTH-entry queue; the match stage pops
// one entry per cycle unless a held result stalls it, runs the eight identifier
// compares and loads the result register. in_ready drops only when the queue is
// full, after out_ready has been low. Configuration writes are always taken
// (cfg_ready is high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module tlv_record_parser_top #(
  parameter int MAX_RECORD  = 131072,
  parameter int SLOTS       = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tlvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         stream_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         has_data,
  output logic [7:0]                   out_byte,
  output logic [7:0]                   slot_mask,
  output logic [15:0]                  data_offset,
  output logic [15:0]                  item_length,
  output logic                         record_end,
  output logic [2:0]                   status
);

  tlvp_pkg::cfg_t   cfg;
  tlvp_pkg::entry_t f_ent, q_ent;
  logic             f_push, q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlvp_pkg::CFG_EXPECTED: cfg.expected_count <= cfg_data[3:0];
        tlvp_pkg::CFG_EXTRA:    cfg.extra_count    <= cfg_data[3:0];
        tlvp_pkg::CFG_IDS_LOW:  cfg.ids_low        <= cfg_data;
        tlvp_pkg::CFG_IDS_HIGH: cfg.ids_high       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tlvp_front #(
    .MAX_RECORD(MAX_RECORD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .full       (q_full),
    .push       (f_push),
    .ent        (f_ent)
  );

  tlvp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wdata   (f_ent),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_ent)
  );

  tlvp_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .ent         (q_ent),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .has_data    (has_data),
    .out_byte    (out_byte),
    .slot_mask   (slot_mask),
    .data_offset (data_offset),
    .item_length (item_length),
    .record_end  (record_end),
    .status      (status)
  );

  a_full_has_entries: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input stalled with an empty queue");

  a_data_has_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data |-> slot_mask != 8'd0)
    else $error("data result without slot match");

  a_offset_in_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data |-> data_offset < item_length)
    else $error("data offset beyond item length");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !record_end |-> status == tlvp_pkg::ST_OK)
    else $error("status set on a non-final result");

endmodule
